// ===== design/btkh_pkg.sv =====
// Shared types, constants and command codes for the bounded top-k max-heap.
// Used by btkh_ctrl, btkh_datapath and bounded_top_k_max_heap_core.
`default_nettype none

package btkh_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int SCORE_W     = 32;
    localparam int ID_W        = 31;
    localparam int RID_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 7;
    localparam int CAP_W       = 7;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 72;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [ID_W-1:0]    id;
    } entry_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED   = 3'd0,
        ST_REPLACED = 3'd1,
        ST_REJECTED = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_REM_LATCH,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_PLACE,
        C_SCAN_START,
        C_SCAN_STEP,
        C_REPLACE,
        C_REJECT,
        C_EMPTY,
        C_REM_START,
        C_REM_LATCH,
        C_UP_READ,
        C_UP_MOVE,
        C_DN_READ,
        C_DN_MOVE,
        C_SETTLE,
        C_PUBLISH
    } dp_cmd_t;

    typedef struct packed {
        logic held_zero;
        logic full;
        logic at_root;
        logic scan_done;
        logic beats_min;
        logic up_move;
        logic down_move;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/btkh_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Holds the heap entries; no dependencies.
`default_nettype none

module btkh_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== design/btkh_datapath.sv =====
// Datapath of the top-k heap: entry RAM, sift and scan registers, result register.
// Depends on btkh_pkg and btkh_ram; driven by commands from btkh_ctrl.
`default_nettype none

module btkh_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [btkh_pkg::CAP_W-1:0]        cfg_wr_data,
    input  wire logic [btkh_pkg::IN_DATA_W-1:0]    in_data,
    input  wire btkh_pkg::dp_cmd_t                 cmd,
    input  wire logic                              m_tready,
    output btkh_pkg::dp_status_t                   stat,
    output logic                                   m_tvalid,
    output logic [btkh_pkg::STATUS_W-1:0]          m_tuser,
    output logic [btkh_pkg::OUT_DATA_W-1:0]        m_tdata
);

    localparam int ADDR_W  = btkh_pkg::ADDR_W;
    localparam int CNT_W   = btkh_pkg::CNT_W;
    localparam int SCORE_W = btkh_pkg::SCORE_W;
    localparam int RID_W   = btkh_pkg::RID_W;
    localparam int IDX_W   = ADDR_W + 2;

    logic [btkh_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0]           held_reg, held_next;
    btkh_pkg::entry_t           cur_reg, cur_next;
    logic [ADDR_W-1:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]           scan_reg, scan_next;
    logic [ADDR_W-1:0]          best_reg, best_next;
    logic signed [SCORE_W-1:0]  min_reg, min_next;
    logic                       first_reg, first_next;
    btkh_pkg::status_t          res_status_reg, res_status_next;
    logic [SCORE_W-1:0]         res_score_reg, res_score_next;
    logic [RID_W-1:0]           res_id_reg, res_id_next;
    logic                       out_valid_reg, out_valid_next;
    btkh_pkg::status_t          out_status_reg, out_status_next;
    logic [SCORE_W-1:0]         out_score_reg, out_score_next;
    logic [RID_W-1:0]           out_id_reg, out_id_next;
    logic [btkh_pkg::COUNT_W-1:0] out_count_reg, out_count_next;

    btkh_pkg::entry_t  in_entry;
    btkh_pkg::entry_t  rd_a;
    btkh_pkg::entry_t  rd_b;
    btkh_pkg::entry_t  child;
    btkh_pkg::entry_t  wdata;
    logic              we;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  cap_half;
    logic [CNT_W-1:0]  scan_addr;
    logic [ADDR_W-1:0] parent;
    logic [CNT_W-1:0]  held_m1;
    logic [IDX_W-1:0]  l_idx;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  held_wide;
    logic              has_l;
    logic              has_r;
    logic              pick_r;
    logic [ADDR_W-1:0] child_idx;

    assign in_entry.score = in_data[SCORE_W-1:0];
    assign in_entry.id    = in_data[SCORE_W+btkh_pkg::ID_W-1:SCORE_W];

    // Zero means one, anything above the store size saturates.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (int'(cap_reg) > btkh_pkg::MAX_ENTRIES)
        begin
            cap_eff = CNT_W'(btkh_pkg::MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign cap_half  = cap_eff >> 1;
    assign scan_addr = scan_reg - CNT_W'(1);
    assign parent    = (pos_reg - ADDR_W'(1)) >> 1;
    assign held_m1   = held_reg - CNT_W'(1);

    // Children of the hole during sift-down; only those below held_count exist.
    assign l_idx     = {1'b0, pos_reg, 1'b1};
    assign r_idx     = l_idx + IDX_W'(1);
    assign held_wide = IDX_W'(held_reg);
    assign has_l     = l_idx < held_wide;
    assign has_r     = r_idx < held_wide;
    assign pick_r    = has_r && !($signed(rd_a.score) > $signed(rd_b.score));
    assign child     = pick_r ? rd_b : rd_a;
    assign child_idx = pick_r ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];

    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        case (cmd)
            btkh_pkg::C_SCAN_START: raddr_a = cap_half[ADDR_W-1:0];
            btkh_pkg::C_SCAN_STEP:  raddr_a = scan_reg[ADDR_W-1:0];
            btkh_pkg::C_REM_START:
            begin
                raddr_a = '0;
                raddr_b = held_m1[ADDR_W-1:0];
            end
            btkh_pkg::C_UP_READ:    raddr_a = parent;
            btkh_pkg::C_DN_READ:
            begin
                raddr_a = l_idx[ADDR_W-1:0];
                raddr_b = r_idx[ADDR_W-1:0];
            end
            default:
            begin
                raddr_a = '0;
                raddr_b = '0;
            end
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        wdata = cur_reg;
        case (cmd)
            btkh_pkg::C_UP_MOVE:
            begin
                we    = 1'b1;
                wdata = rd_a;
            end
            btkh_pkg::C_DN_MOVE:
            begin
                we    = 1'b1;
                wdata = child;
            end
            btkh_pkg::C_SETTLE:
            begin
                we    = 1'b1;
                wdata = cur_reg;
            end
            default:
            begin
                we    = 1'b0;
                wdata = cur_reg;
            end
        endcase
    end

    btkh_ram #(
        .DEPTH (btkh_pkg::MAX_ENTRIES),
        .WIDTH ($bits(btkh_pkg::entry_t))
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (pos_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        held_next       = held_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        scan_next       = scan_reg;
        best_next       = best_reg;
        min_next        = min_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_score_next  = res_score_reg;
        res_id_next     = res_id_reg;
        out_status_next = out_status_reg;
        out_score_next  = out_score_reg;
        out_id_next     = out_id_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        case (cmd)
            btkh_pkg::C_PLACE:
            begin
                cur_next        = in_entry;
                pos_next        = held_reg[ADDR_W-1:0];
                held_next       = held_reg + CNT_W'(1);
                res_status_next = btkh_pkg::ST_PLACED;
                res_score_next  = '0;
                res_id_next     = '1;
            end
            btkh_pkg::C_SCAN_START:
            begin
                cur_next       = in_entry;
                scan_next      = cap_half + CNT_W'(1);
                first_next     = 1'b1;
                res_score_next = '0;
                res_id_next    = '1;
            end
            btkh_pkg::C_SCAN_STEP:
            begin
                // Strict less-than keeps the lowest position on ties.
                if (first_reg || ($signed(rd_a.score) < min_reg))
                begin
                    min_next  = rd_a.score;
                    best_next = scan_addr[ADDR_W-1:0];
                end
                first_next = 1'b0;
                scan_next  = scan_reg + CNT_W'(1);
            end
            btkh_pkg::C_REPLACE:
            begin
                pos_next        = best_reg;
                res_status_next = btkh_pkg::ST_REPLACED;
            end
            btkh_pkg::C_REJECT:
            begin
                res_status_next = btkh_pkg::ST_REJECTED;
            end
            btkh_pkg::C_EMPTY:
            begin
                res_status_next = btkh_pkg::ST_EMPTY;
                res_score_next  = '0;
                res_id_next     = '1;
            end
            btkh_pkg::C_REM_START:
            begin
                held_next       = held_m1;
                res_status_next = btkh_pkg::ST_REMOVED;
            end
            btkh_pkg::C_REM_LATCH:
            begin
                res_score_next = rd_a.score;
                res_id_next    = RID_W'(rd_a.id);
                cur_next       = rd_b;
                pos_next       = '0;
            end
            btkh_pkg::C_UP_MOVE:
            begin
                pos_next = parent;
            end
            btkh_pkg::C_DN_MOVE:
            begin
                pos_next = child_idx;
            end
            btkh_pkg::C_PUBLISH:
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status_reg;
                out_score_next  = res_score_reg;
                out_id_next     = res_id_reg;
                out_count_next  = btkh_pkg::COUNT_W'(held_reg);
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= btkh_pkg::CAP_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        scan_reg       <= scan_next;
        best_reg       <= best_next;
        min_reg        <= min_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_score_reg  <= res_score_next;
        res_id_reg     <= res_id_next;
        out_status_reg <= out_status_next;
        out_score_reg  <= out_score_next;
        out_id_reg     <= out_id_next;
        out_count_reg  <= out_count_next;
    end

    assign stat.held_zero = (held_reg == '0);
    assign stat.full      = (held_reg >= cap_eff);
    assign stat.at_root   = (pos_reg == '0);
    assign stat.scan_done = (scan_reg == cap_eff);
    assign stat.beats_min = ($signed(cur_reg.score) > min_reg);
    assign stat.up_move   = ($signed(cur_reg.score) > $signed(rd_a.score));
    assign stat.down_move = has_l && ($signed(child.score) > $signed(cur_reg.score));
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_id_reg, out_score_reg};

endmodule

`default_nettype wire

// ===== design/btkh_ctrl.sv =====
// Sequencer of the top-k heap: picks the operation and steps scan and sifts.
// Depends on btkh_pkg; drives btkh_datapath through command and status.
`default_nettype none

module btkh_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 kind,
    input  wire btkh_pkg::dp_status_t stat,
    output logic                      s_tready,
    output btkh_pkg::dp_cmd_t         cmd
);

    btkh_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btkh_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = btkh_pkg::C_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            btkh_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (kind == btkh_pkg::KIND_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd        = btkh_pkg::C_SCAN_START;
                            state_next = btkh_pkg::S_SCAN;
                        end
                        else
                        begin
                            cmd        = btkh_pkg::C_PLACE;
                            state_next = btkh_pkg::S_UP_RD;
                        end
                    end
                    else if (stat.held_zero)
                    begin
                        cmd        = btkh_pkg::C_EMPTY;
                        state_next = btkh_pkg::S_FINISH;
                    end
                    else
                    begin
                        cmd        = btkh_pkg::C_REM_START;
                        state_next = btkh_pkg::S_REM_LATCH;
                    end
                end
            end
            btkh_pkg::S_SCAN:
            begin
                cmd = btkh_pkg::C_SCAN_STEP;
                if (stat.scan_done)
                begin
                    state_next = btkh_pkg::S_DECIDE;
                end
            end
            btkh_pkg::S_DECIDE:
            begin
                if (stat.beats_min)
                begin
                    cmd        = btkh_pkg::C_REPLACE;
                    state_next = btkh_pkg::S_UP_RD;
                end
                else
                begin
                    cmd        = btkh_pkg::C_REJECT;
                    state_next = btkh_pkg::S_FINISH;
                end
            end
            btkh_pkg::S_UP_RD:
            begin
                if (stat.at_root)
                begin
                    cmd        = btkh_pkg::C_SETTLE;
                    state_next = btkh_pkg::S_FINISH;
                end
                else
                begin
                    cmd        = btkh_pkg::C_UP_READ;
                    state_next = btkh_pkg::S_UP_CMP;
                end
            end
            btkh_pkg::S_UP_CMP:
            begin
                // Pull the parent down into the hole, or drop the new entry here.
                if (stat.up_move)
                begin
                    cmd        = btkh_pkg::C_UP_MOVE;
                    state_next = btkh_pkg::S_UP_RD;
                end
                else
                begin
                    cmd        = btkh_pkg::C_SETTLE;
                    state_next = btkh_pkg::S_FINISH;
                end
            end
            btkh_pkg::S_REM_LATCH:
            begin
                cmd        = btkh_pkg::C_REM_LATCH;
                state_next = btkh_pkg::S_DN_RD;
            end
            btkh_pkg::S_DN_RD:
            begin
                cmd        = btkh_pkg::C_DN_READ;
                state_next = btkh_pkg::S_DN_CMP;
            end
            btkh_pkg::S_DN_CMP:
            begin
                if (stat.down_move)
                begin
                    cmd        = btkh_pkg::C_DN_MOVE;
                    state_next = btkh_pkg::S_DN_RD;
                end
                else
                begin
                    cmd        = btkh_pkg::C_SETTLE;
                    state_next = btkh_pkg::S_FINISH;
                end
            end
            btkh_pkg::S_FINISH:
            begin
                // Hold the result until the output register is free.
                if (stat.out_free)
                begin
                    cmd        = btkh_pkg::C_PUBLISH;
                    state_next = btkh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btkh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/bounded_top_k_max_heap_core.sv =====
// Bounded top-k max-heap of (score, id) pairs: controller plus datapath.
// Depends on btkh_pkg, btkh_ctrl, btkh_datapath (and btkh_ram below it).
//
// Usage:
//   Requests enter on the s_ stream: s_tuser is the kind (0 insert, 1 remove
//   the maximum), s_tdata carries score and entry_id. Every request yields
//   exactly one result on the m_ stream: m_tuser is the status, m_tdata
//   carries removed_score, removed_id and entry_count.
//   capacity is written through cfg_wr_en/cfg_wr_data while the core is idle.
//   The core works on one request at a time; entries live in a 64-deep RAM
//   with one write and two registered read ports, and every heap level passes
//   through a read state and a compare state.
//   An insert with room places the entry last and sifts it up (up to 6 levels);
//   a remove takes the root, moves the last entry up and sifts it down. A full
//   heap insert scans n = capacity - capacity/2 leaves, one per cycle, then
//   rejects or replaces the lowest-position minimum leaf and sifts the new entry up.
//   The next request is taken the cycle after a result is loaded into the
//   output register, even if that result is still waiting.
//   A stalled receiver holds the output register; the next result waits.
//   Reset empties the heap, sets capacity to 64 and clears m_tvalid.
`default_nettype none

module bounded_top_k_max_heap_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [btkh_pkg::IN_DATA_W-1:0]     s_tdata,   // score, entry_id, pad
    input  wire logic                               s_tuser,   // kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [btkh_pkg::OUT_DATA_W-1:0]         m_tdata,   // removed_score, removed_id,
                                                               // entry_count, pad
    output logic [btkh_pkg::STATUS_W-1:0]           m_tuser,   // status
    input  wire logic                               cfg_wr_en,
    input  wire logic [btkh_pkg::CAP_W-1:0]         cfg_wr_data
);

    btkh_pkg::dp_cmd_t    cmd;
    btkh_pkg::dp_status_t stat;

    btkh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .kind     (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    btkh_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_tdata),
        .cmd         (cmd),
        .m_tready    (m_tready),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    a_one_request_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while one is in flight");

    a_removed_id_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == btkh_pkg::ST_REMOVED)) |-> !m_tdata[63])
        else $error("removed entry carries a negative id");

    a_no_removal_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != btkh_pkg::ST_REMOVED))
        |-> ((m_tdata[63:32] == '1) && (m_tdata[31:0] == '0)))
        else $error("non-remove result carries removal fields");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[70:64] <= btkh_pkg::COUNT_W'(btkh_pkg::MAX_ENTRIES)))
        else $error("entry count exceeds store size");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/heap_result_checker.sv =====
// Checker for the bounded top-k max-heap core: keeps its own heap and capacity,
// predicts one result per accepted request, and compares the results in order.
// Depends on btkh_pkg for the kind and status codes and the heap depth.
module heap_result_checker
    import btkh_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [IN_DATA_W-1:0]    s_tdata,   // score, entry_id, pad
    input  wire logic                    s_tuser,   // kind
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [OUT_DATA_W-1:0]   m_tdata,   // removed_score, removed_id,
                                                    // entry_count, pad
    input  wire logic [STATUS_W-1:0]     m_tuser,   // status
    input  wire logic                    cfg_wr_en,
    input  wire logic [CAP_W-1:0]        cfg_wr_data,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                   status;
        logic signed [SCORE_W-1:0] score;
        logic signed [RID_W-1:0]   id;
        logic [COUNT_W-1:0]        count;
    } heap_result_t;

    logic signed [SCORE_W-1:0] slot_score [MAX_ENTRIES];
    logic signed [RID_W-1:0]   slot_id    [MAX_ENTRIES];
    int unsigned               held;
    logic [CAP_W-1:0]          capacity;
    heap_result_t              due_results [$];
    int                        mismatch_count = 0;

    assign errors = mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns heap check: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic swap_slots(input int unsigned a, input int unsigned b);
        logic signed [SCORE_W-1:0] s;
        logic signed [RID_W-1:0]   d;
        s = slot_score[a];
        d = slot_id[a];
        slot_score[a] = slot_score[b];
        slot_id[a] = slot_id[b];
        slot_score[b] = s;
        slot_id[b] = d;
    endtask

    task automatic heap_op(input kind_t kind, input logic signed [SCORE_W-1:0] score,
                           input logic [ID_W-1:0] id, output heap_result_t res);
        int unsigned cap;
        int unsigned pos;
        int unsigned best;
        int unsigned i;
        int unsigned lc;
        int unsigned rc;
        int unsigned pick;
        logic        place;
        logic        sinking;
        res.status = ST_EMPTY;
        res.score = '0;
        res.id = '1;
        if (capacity == 0)
            cap = 1;
        else if (capacity > MAX_ENTRIES)
            cap = MAX_ENTRIES;
        else
            cap = capacity;
        if (kind == KIND_INSERT)
        begin
            place = 1'b1;
            if (held < cap)
            begin
                pos = held;
                held++;
                res.status = ST_PLACED;
            end
            else
            begin
                // full: lowest-position minimum among the leaves of the effective capacity
                best = cap / 2;
                for (i = cap / 2; i < cap; i++)
                    if (slot_score[i] < slot_score[best])
                        best = i;
                pos = best;
                if (score > slot_score[best])
                    res.status = ST_REPLACED;
                else
                begin
                    res.status = ST_REJECTED;
                    place = 1'b0;
                end
            end
            if (place)
            begin
                slot_score[pos] = score;
                slot_id[pos] = {1'b0, id};
                while (pos > 0 && slot_score[pos] > slot_score[(pos - 1) / 2])
                begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
        end
        else if (held != 0)
        begin
            res.status = ST_REMOVED;
            res.score = slot_score[0];
            res.id = slot_id[0];
            held--;
            slot_score[0] = slot_score[held];
            slot_id[0] = slot_id[held];
            pos = 0;
            sinking = 1'b1;
            while (sinking)
            begin
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                if (lc >= held)
                    sinking = 1'b0;
                else
                begin
                    // equal children: take the right one
                    if (rc < held && !(slot_score[lc] > slot_score[rc]))
                        pick = rc;
                    else
                        pick = lc;
                    if (slot_score[pick] > slot_score[pos])
                    begin
                        swap_slots(pick, pos);
                        pos = pick;
                    end
                    else
                        sinking = 1'b0;
                end
            end
        end
        res.count = COUNT_W'(held);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        heap_result_t want;
        heap_result_t got;
        int           i;
        if (!rst_n)
        begin
            for (i = 0; i < MAX_ENTRIES; i++)
            begin
                slot_score[i] = '0;
                slot_id[i] = '1;
            end
            held = 0;
            capacity = CAP_RESET;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tuser);
                got.score = m_tdata[31:0];
                got.id = m_tdata[63:32];
                got.count = m_tdata[70:64];
                if (due_results.size() == 0)
                    report_mismatch("result with no request waiting", 32'(m_tuser), '0);
                else
                begin
                    want = due_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.score != want.score)
                        report_mismatch("removed_score", got.score, want.score);
                    if (got.id != want.id)
                        report_mismatch("removed_id", got.id, want.id);
                    if (got.count != want.count)
                        report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                end
            end
            if (s_tvalid && s_tready)
            begin
                heap_op(kind_t'(s_tuser), s_tdata[31:0], s_tdata[62:32], want);
                due_results.push_back(want);
            end
            pending <= due_results.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the top-k max-heap testbench: clock, reset, request and stall stimulus,
// capacity writes and the verdict. Depends on btkh_pkg, the core and heap_result_checker.
module tb;
    import btkh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 64;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]        cfg_wr_data = '0;

    int chk_errors;
    int chk_pending;
    int send_idle_pct = 33;
    int recv_stall_pct = 51;
    int quiet_cycles = 0;

    bounded_top_k_max_heap_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    heap_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (chk_errors),
        .pending     (chk_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_request(input kind_t kind, input logic [31:0] score,
                                input logic [30:0] id);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, id, score};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // drop valid and hold off until every request has its result
    task automatic wait_heap_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_heap_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_score(input int mode);
        logic [31:0] v;
        v = $urandom;
        if (mode == 1)
            v = 32'($urandom_range(0, 15)) - 32'd8;
        else if (mode == 2)
        begin
            case ($urandom_range(0, 3))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = 32'($urandom_range(0, 3)) - 32'd2;
                default: v = $urandom;
            endcase
        end
        return v;
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CAP_W'(1);
            2: return CAP_W'($urandom_range(2, 8));
            3: return CAP_W'($urandom_range(9, 63));
            6: return CAP_W'($urandom_range(65, 126));
            7: return '1;
            default: return CAP_W'(64);
        endcase
    endfunction

    // blocks of requests, each under a fresh capacity and insert/remove mix
    task automatic run_phase(input int n_items);
        int   sent;
        int   block_len;
        int   insert_pct;
        int   score_mode;
        kind_t kind;
        sent = 0;
        while (sent < n_items)
        begin
            write_capacity(pick_capacity());
            block_len = $urandom_range(20, 90);
            if (block_len > n_items - sent)
                block_len = n_items - sent;
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 60;
                default: insert_pct = 30;
            endcase
            score_mode = $urandom_range(0, 2);
            repeat (block_len)
            begin
                kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
                send_request(kind, pick_score(score_mode), 31'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove from the empty heap, then fill a heap of four with extremes
        send_request(KIND_REMOVE, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        write_capacity(CAP_W'(4));
        send_request(KIND_INSERT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_request(KIND_INSERT, 32'h8000_0000, 31'h0);
        send_request(KIND_INSERT, 32'h0000_0000, 31'h2AAA_AAAA);
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 31'h5555_5555);
        send_request(KIND_INSERT, 32'h8000_0000, 31'd7);
        send_request(KIND_INSERT, 32'd3, 31'd8);
        send_request(KIND_INSERT, 32'd3, 31'd9);
        send_request(KIND_INSERT, 32'h7FFF_FFFF, 31'd10);
        // shrink capacity below the held count
        write_capacity(CAP_W'(2));
        send_request(KIND_INSERT, 32'd100, 31'd11);
        send_request(KIND_INSERT, 32'hFFFF_FFFB, 31'd12);
        repeat (5) send_request(KIND_REMOVE, 32'h0, 31'h0);
        // zero capacity acts as one
        write_capacity('0);
        send_request(KIND_INSERT, 32'd1, 31'd13);
        send_request(KIND_INSERT, 32'd2, 31'd14);
        send_request(KIND_INSERT, 32'd2, 31'd15);
        repeat (2) send_request(KIND_REMOVE, 32'h0, 31'h0);
        // oversized capacity saturates; equal scores exercise sift-down ties
        write_capacity('1);
        repeat (3) send_request(KIND_INSERT, 32'hFFFF_FFFE, 31'($urandom));
        send_request(KIND_REMOVE, 32'h0, 31'h0);

        run_phase(190);
        wait_heap_idle();
        send_idle_pct = 51;
        recv_stall_pct = 33;
        run_phase(190);
        wait_heap_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_phase(190);
        wait_heap_idle();

        if (chk_errors == 0 && chk_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/btkh_pkg.sv
design/btkh_ram.sv
design/btkh_datapath.sv
design/btkh_ctrl.sv
design/bounded_top_k_max_heap_core.sv
tb/sv/heap_result_checker.sv
tb/sv/tb.sv
